// ===== hw/rtl/parallel_flash_command_interface_assert.svh =====
// assertion macros shared by the flash command interface modules
`ifndef PARALLEL_FLASH_COMMAND_INTERFACE_ASSERT_SVH
`define PARALLEL_FLASH_COMMAND_INTERFACE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PFCI_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfci assertion failed");

// next-cycle implication, checked out of reset
`define PFCI_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfci assertion failed");

`endif

// ===== hw/rtl/pfci_pkg.sv =====
// types and command codes of the parallel flash command interface
`default_nettype none

package pfci_pkg;

  // command codes of the first and of the second bus write of a command
  localparam logic [7:0] CODE_ALT_WRITE     = 8'h10;
  localparam logic [7:0] CODE_ERASE_SETUP   = 8'h20;
  localparam logic [7:0] CODE_WRITE         = 8'h40;
  localparam logic [7:0] CODE_STS_CLEAR     = 8'h50;
  localparam logic [7:0] CODE_STS_READ      = 8'h70;
  localparam logic [7:0] CODE_READ_ID       = 8'h90;
  localparam logic [7:0] CODE_ERASE_SUSPEND = 8'hB0;
  localparam logic [7:0] CODE_ERASE_CONFIRM = 8'hD0;
  localparam logic [7:0] CODE_ARRAY_READ    = 8'hFF;

  // status byte bits and the erased data value
  localparam logic [7:0] STATUS_ERR_BITS = 8'h30;
  localparam logic [7:0] ERASED_BYTE     = 8'hFF;

  // access kinds
  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_MOD,
    S_EXEC,
    S_EMUL,
    S_EALIGN,
    S_RESP
  } pfci_state_e;

  // strobes from controller to datapath
  typedef struct packed {
    logic load;
    logic mod;
    logic exec;
    logic emul;
    logic ealign;
    logic sweep;
    logic out_load;
  } pfci_ctl_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_write;
    logic erase_req;
    logic sweep_last;
    logic out_free;
  } pfci_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/parallel_flash_command_interface.sv =====
// top level of the byte-wide parallel flash command interface
`default_nettype none

// Byte-wide flash with a command decoder: every transaction is one bus read or
// write. A read runs through accept, address wrap, array read and the result
// register, a write through accept, address wrap and execute; a new
// transaction is taken once the previous one leaves the controller, and a
// finished read may wait in the output register while the next transaction is
// accepted. A block erase confirm adds block alignment (EMUL, EALIGN), then
// writes one byte per cycle, BLOCK_BYTES bytes (fewer for a block clipped at
// the array end), with the input stalled. After reset the array is filled with
// 0xFF by a clearing pass over all FLASH_BYTES bytes, during which no
// transaction is accepted; the device_id register can be written at any time.
// The single array write port sets the pace of erase and of the clearing pass.
module parallel_flash_command_interface #(
  parameter int FLASH_BYTES = 65536,
  parameter int BLOCK_BYTES = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        cmd_i,
  input  wire logic [15:0] addr_i,
  input  wire logic [7:0]  wdata_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       rdata_o
);

  pfci_pkg::pfci_ctl_t ctl;
  pfci_pkg::pfci_sts_t sts;

  // sequencing
  pfci_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // array and command datapath
  pfci_dp #(
    .FLASH_BYTES (FLASH_BYTES),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .cmd_i       (cmd_i),
    .addr_i      (addr_i),
    .wdata_i     (wdata_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .rdata_o     (rdata_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/pfci_ctrl.sv =====
// sequencing state machine of the flash command interface
`default_nettype none
`include "parallel_flash_command_interface_assert.svh"

module pfci_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire pfci_pkg::pfci_sts_t sts_i,
  output pfci_pkg::pfci_ctl_t     ctl_o
);

  pfci_pkg::pfci_state_e state_q, state_d;

  // state register, reset starts the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfci_pkg::S_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and strobes
  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      pfci_pkg::S_SWEEP: begin
        ctl_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = pfci_pkg::S_IDLE;
        end
      end
      pfci_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = pfci_pkg::S_MOD;
        end
      end
      pfci_pkg::S_MOD: begin
        ctl_o.mod = 1'b1;
        state_d   = pfci_pkg::S_EXEC;
      end
      pfci_pkg::S_EXEC: begin
        ctl_o.exec = 1'b1;
        if (!sts_i.is_write) begin
          state_d = pfci_pkg::S_RESP;
        end else if (sts_i.erase_req) begin
          state_d = pfci_pkg::S_EMUL;
        end else begin
          state_d = pfci_pkg::S_IDLE;
        end
      end
      pfci_pkg::S_EMUL: begin
        ctl_o.emul = 1'b1;
        state_d    = pfci_pkg::S_EALIGN;
      end
      pfci_pkg::S_EALIGN: begin
        ctl_o.ealign = 1'b1;
        state_d      = pfci_pkg::S_SWEEP;
      end
      pfci_pkg::S_RESP: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          state_d        = pfci_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pfci_pkg::S_IDLE;
      end
    endcase
  end

  // an erase confirm always runs the block alignment then the sweep
  `PFCI_ASSERT_NEXT(a_erase_starts, clk_i, rst_ni,
                    state_q == pfci_pkg::S_EXEC && sts_i.is_write && sts_i.erase_req,
                    state_q == pfci_pkg::S_EMUL)
  // a finished sweep hands back to idle
  `PFCI_ASSERT_NEXT(a_sweep_ends, clk_i, rst_ni,
                    state_q == pfci_pkg::S_SWEEP && sts_i.sweep_last,
                    state_q == pfci_pkg::S_IDLE)

endmodule

`default_nettype wire

// ===== hw/rtl/pfci_dp.sv =====
// datapath: address wrap, flash array, command registers and read mux
`default_nettype none
`include "parallel_flash_command_interface_assert.svh"

module pfci_dp #(
  parameter int FLASH_BYTES = 65536,
  parameter int BLOCK_BYTES = 4096
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire pfci_pkg::pfci_ctl_t ctl_i,
  output pfci_pkg::pfci_sts_t      sts_o,
  input  wire logic                cmd_i,
  input  wire logic [15:0]         addr_i,
  input  wire logic [7:0]          wdata_i,
  input  wire logic                cfg_we_i,
  input  wire logic [15:0]         cfg_wdata_i,
  input  wire logic                out_stall_i,
  output logic                     out_valid_o,
  output logic [7:0]               rdata_o
);

  localparam int AW  = $clog2(FLASH_BYTES);
  localparam int PW  = AW + 1;
  localparam int WW  = ((AW > 16) ? AW : 16) + 1;
  localparam int XW  = ((AW > 16) ? AW : 16) + 2;
  localparam int QW  = AW + 9;
  localparam int BW2 = 2 * AW + 1;
  localparam int MW  = AW + 16;
  localparam logic [24:0] RECIP_F = 25'((64'd1 << 32) / FLASH_BYTES);
  localparam logic [PW-1:0] RECIP_B = PW'((64'd1 << AW) / BLOCK_BYTES);

  // transaction registers
  logic          cmd_q;
  logic [15:0]   addr_q;
  logic [7:0]    wdata_q;
  logic [7:0]    qf_q;
  logic [WW-1:0] r0_q;

  // command state
  logic [7:0]  cur_q, cur_d;
  logic [7:0]  status_q, status_d;
  logic        second_q, second_d;
  logic [15:0] device_id_q;

  // erase and sweep registers
  logic [AW-1:0] qb_q;
  logic [AW-1:0] pb_q;
  logic [PW-1:0] ptr_q;
  logic [PW-1:0] end_q;

  // array and output
  logic [7:0] mem_q [FLASH_BYTES];
  logic [7:0] mem_rdata_q;
  logic       out_valid_q;
  logic [7:0] rdata_q;

  // wires
  logic [40:0]    prod_f;
  logic [QW-1:0]  prod_q;
  logic [WW-1:0]  r0_d;
  logic [WW-1:0]  r0_sub;
  logic [WW-1:0]  off_w;
  logic [AW-1:0]  off;
  logic [BW2-1:0] prod_b;
  logic [MW-1:0]  prod_pb;
  logic [AW-1:0]  rem;
  logic [XW-1:0]  start_x;
  logic [XW-1:0]  end_x;
  logic [XW-1:0]  end_clip;
  logic           prog_we;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [7:0]     mem_wdata;
  logic [7:0]     read_val;

  // first wrap stage: estimated quotient of addr by the array size
  assign prod_f = 41'(addr_i) * 41'(RECIP_F);

  // second wrap stage: remainder before correction
  assign prod_q = QW'(qf_q) * QW'(FLASH_BYTES);
  assign r0_d   = WW'(addr_q) - WW'(prod_q);

  // final correction gives the wrapped offset
  assign r0_sub = r0_q - WW'(FLASH_BYTES);
  assign off_w  = (r0_q >= WW'(FLASH_BYTES)) ? r0_sub : r0_q;
  assign off    = off_w[AW-1:0];

  // block alignment of the erase offset
  assign prod_b   = BW2'(off) * BW2'(RECIP_B);
  assign prod_pb  = MW'(qb_q) * MW'(BLOCK_BYTES);
  assign rem      = off - pb_q;
  assign start_x  = XW'(pb_q) + ((XW'(rem) >= XW'(BLOCK_BYTES)) ? XW'(BLOCK_BYTES) : XW'(0));
  assign end_x    = start_x + XW'(BLOCK_BYTES);
  assign end_clip = (end_x > XW'(FLASH_BYTES)) ? XW'(FLASH_BYTES) : end_x;

  // transaction, wrap and erase alignment pipeline registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q   <= cmd_i;
      addr_q  <= addr_i;
      wdata_q <= wdata_i;
      qf_q    <= prod_f[39:32];
    end
    if (ctl_i.mod) begin
      r0_q <= r0_d;
    end
    if (ctl_i.exec) begin
      qb_q <= prod_b[2*AW-1:AW];
    end
    if (ctl_i.emul) begin
      pb_q <= prod_pb[AW-1:0];
    end
  end

  // command decoder for write transactions
  always_comb begin
    cur_d    = cur_q;
    status_d = status_q;
    second_d = second_q;
    prog_we  = 1'b0;
    if (ctl_i.exec && cmd_q == pfci_pkg::ACC_WRITE) begin
      if (!second_q) begin
        unique case (wdata_q) inside
          pfci_pkg::CODE_ARRAY_READ, pfci_pkg::CODE_STS_READ,
          pfci_pkg::CODE_ERASE_SUSPEND, pfci_pkg::CODE_READ_ID: begin
            cur_d = wdata_q;
          end
          pfci_pkg::CODE_STS_CLEAR: begin
            status_d = '0;
            cur_d    = pfci_pkg::CODE_ARRAY_READ;
          end
          pfci_pkg::CODE_WRITE, pfci_pkg::CODE_ALT_WRITE, pfci_pkg::CODE_ERASE_SETUP: begin
            cur_d    = wdata_q;
            second_d = 1'b1;
          end
          default: begin
            cur_d = cur_q;
          end
        endcase
      end else begin
        unique case (cur_q) inside
          pfci_pkg::CODE_WRITE, pfci_pkg::CODE_ALT_WRITE: begin
            prog_we = 1'b1;
          end
          pfci_pkg::CODE_ERASE_SETUP: begin
            if (wdata_q != pfci_pkg::CODE_ERASE_CONFIRM) begin
              cur_d    = pfci_pkg::CODE_STS_READ;
              status_d = status_q | pfci_pkg::STATUS_ERR_BITS;
            end
          end
          default: begin
            cur_d = cur_q;
          end
        endcase
        second_d = 1'b0;
      end
    end
  end

  // command state and configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= pfci_pkg::CODE_ARRAY_READ;
      status_q    <= '0;
      second_q    <= 1'b0;
      device_id_q <= '0;
    end else begin
      cur_q    <= cur_d;
      status_q <= status_d;
      second_q <= second_d;
      if (cfg_we_i) begin
        device_id_q <= cfg_wdata_i;
      end
    end
  end

  // sweep pointer, reset sets up the clearing pass over the whole array
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      end_q <= PW'(FLASH_BYTES);
    end else if (ctl_i.ealign) begin
      ptr_q <= PW'(start_x);
      end_q <= PW'(end_clip);
    end else if (ctl_i.sweep) begin
      ptr_q <= ptr_q + PW'(1);
    end
  end

  // array write port: sweep fill or byte program
  assign mem_we    = ctl_i.sweep | prog_we;
  assign mem_waddr = ctl_i.sweep ? ptr_q[AW-1:0] : off;
  assign mem_wdata = ctl_i.sweep ? pfci_pkg::ERASED_BYTE : wdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  // array read port
  always_ff @(posedge clk_i) begin
    if (ctl_i.exec) begin
      mem_rdata_q <= mem_q[off];
    end
  end

  // read data select by current mode
  always_comb begin
    unique case (cur_q)
      pfci_pkg::CODE_ARRAY_READ: read_val = mem_rdata_q;
      pfci_pkg::CODE_STS_READ:   read_val = status_q;
      pfci_pkg::CODE_READ_ID:    read_val = off[0] ? device_id_q[15:8] : device_id_q[7:0];
      default:                   read_val = 8'hFF;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      rdata_q <= read_val;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rdata_o     = rdata_q;

  // status to the controller
  assign sts_o.is_write   = cmd_q;
  assign sts_o.erase_req  = second_q && cur_q == pfci_pkg::CODE_ERASE_SETUP &&
                            wdata_q == pfci_pkg::CODE_ERASE_CONFIRM;
  assign sts_o.sweep_last = (ptr_q + PW'(1)) == end_q;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  // the sweep and a byte program never share the write port
  `PFCI_ASSERT_IMPL(a_one_writer, clk_i, rst_ni, 1'b1, $onehot0({ctl_i.sweep, prog_we}))
  // a pending second write belongs to a command that takes a second write
  `PFCI_ASSERT_IMPL(a_second_cmd, clk_i, rst_ni, second_q,
                    cur_q == pfci_pkg::CODE_WRITE || cur_q == pfci_pkg::CODE_ALT_WRITE ||
                    cur_q == pfci_pkg::CODE_ERASE_SETUP)
  // the sweep stays inside the array and its block
  `PFCI_ASSERT_IMPL(a_sweep_range, clk_i, rst_ni, ctl_i.sweep,
                    ptr_q < end_q && end_q <= PW'(FLASH_BYTES))

endmodule

`default_nettype wire
